// ----- hw/rtl/pkeyer_pkg.sv -----
// package for the paddle keyer: phase and element codes, widths, dit clamp
// no dependencies
`default_nettype none

package pkeyer_pkg;

  localparam int unsigned DIT_W      = 11;
  localparam int unsigned REM_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [DIT_W-1:0] DIT_MS_MAX   = 11'd1200;
  localparam logic [DIT_W-1:0] DIT_MS_RESET = 11'd60;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    START_NONE = 2'd0,
    START_DIT  = 2'd1,
    START_DAH  = 2'd2
  } start_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIT_MS          = 2'd0,
    REG_ACTIVE_LOW      = 2'd1,
    REG_SIDETONE_ENABLE = 2'd2,
    REG_PADDLE_ENABLE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic   key_down;
    start_t start;
    logic   busy;
  } step_res_t;

  function automatic logic [REM_W-1:0] unit_len(input logic [DIT_W-1:0] d);
    logic [DIT_W-1:0] c;
    c = d;
    if (c == '0) c = DIT_W'(1);
    if (c > DIT_MS_MAX) c = DIT_MS_MAX;
    return REM_W'(c);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pkeyer_core.sv -----
// keyer state: phase, element kind, countdown, paddle memories and key state
// depends on pkeyer_pkg
`default_nettype none

module pkeyer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          dit,
  input  wire logic                          dah,
  input  wire logic                          sk,
  input  wire logic                          paddle_enable,
  input  wire logic [pkeyer_pkg::DIT_W-1:0]  dit_ms,
  output pkeyer_pkg::step_res_t              res
);
  import pkeyer_pkg::*;

  phase_t           phase, phase_next;
  logic             sending_dah, sending_dah_next;
  logic [REM_W-1:0] remaining_ms, remaining_ms_next;
  logic             remember_dit, remember_dit_next;
  logic             remember_dah, remember_dah_next;
  logic             key_is_down, key_is_down_next;

  logic [REM_W-1:0] unit;
  logic [REM_W-1:0] unit3;
  logic [REM_W-1:0] rem_dec;
  logic             running;
  logic             mem_dit;
  logic             mem_dah;
  logic             dit_go;
  logic             dah_go;
  logic             chain_dah;

  assign unit      = unit_len(dit_ms);
  assign unit3     = REM_W'({unit, 1'b0}) + unit;
  assign running   = (phase == PH_MARK) || (phase == PH_SPACE);
  assign rem_dec   = (remaining_ms != '0) ? remaining_ms - REM_W'(1) : '0;
  assign mem_dit   = remember_dit | dit;
  assign mem_dah   = remember_dah | dah;
  assign dit_go    = !running && paddle_enable && mem_dit;
  assign dah_go    = !running && paddle_enable && !mem_dit && mem_dah;
  assign chain_dah = (phase == PH_SPACE) && (rem_dec == '0) && !sending_dah && mem_dah;

  always_comb begin
    phase_next        = phase;
    sending_dah_next  = sending_dah;
    remaining_ms_next = remaining_ms;
    remember_dit_next = remember_dit;
    remember_dah_next = remember_dah;
    key_is_down_next  = key_is_down;
    case (phase)
      PH_MARK, PH_SPACE: begin
        remember_dit_next = mem_dit;
        remember_dah_next = mem_dah;
        remaining_ms_next = rem_dec;
        if (rem_dec == '0) begin
          if (phase == PH_MARK) begin
            key_is_down_next  = 1'b0;
            phase_next        = PH_SPACE;
            remaining_ms_next = unit;
          end else if (sending_dah) begin
            remember_dah_next = 1'b0;
            phase_next        = PH_IDLE;
          end else begin
            remember_dit_next = 1'b0;
            if (mem_dah) begin
              sending_dah_next  = 1'b1;
              key_is_down_next  = 1'b1;
              phase_next        = PH_MARK;
              remaining_ms_next = unit3;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        key_is_down_next = sk;
        if (dit_go || dah_go) begin
          sending_dah_next  = dah_go;
          key_is_down_next  = 1'b1;
          phase_next        = PH_MARK;
          remaining_ms_next = dah_go ? unit3 : unit;
        end
      end
    endcase
  end

  always_comb begin
    res.key_down = key_is_down_next;
    res.busy     = (phase_next != PH_IDLE);
    if (dit_go) begin
      res.start = START_DIT;
    end else if (dah_go || chain_dah) begin
      res.start = START_DAH;
    end else begin
      res.start = START_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sending_dah  <= 1'b0;
      remaining_ms <= '0;
      remember_dit <= 1'b0;
      remember_dah <= 1'b0;
      key_is_down  <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      sending_dah  <= sending_dah_next;
      remaining_ms <= remaining_ms_next;
      remember_dit <= remember_dit_next;
      remember_dah <= remember_dah_next;
      key_is_down  <= key_is_down_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/paddle_keyer_with_element_memory.sv -----
// paddle keyer top: config registers, keyer state and output register
// an accepted tick word's result word is registered and valid in the next cycle
// throughput one word per cycle while out_ready is high, input taken while the output register drains
// synchronous active-high reset: idle, key up, memories clear, config registers to defaults
// depends on pkeyer_pkg and pkeyer_core
`default_nettype none

module paddle_keyer_with_element_memory (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pkeyer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pkeyer_pkg::DIT_W-1:0]      cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              dit_paddle,
  input  wire logic                              dah_paddle,
  input  wire logic                              straight_key,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   key_line,
  output logic                                   sidetone_on,
  output logic [1:0]                             element_start,
  output logic                                   busy_res
);
  import pkeyer_pkg::*;

  logic [DIT_W-1:0] dit_ms;
  logic             active_low;
  logic             sidetone_enable;
  logic             paddle_enable;
  logic             accept;
  step_res_t        res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dit_ms          <= DIT_MS_RESET;
      active_low      <= 1'b0;
      sidetone_enable <= 1'b1;
      paddle_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIT_MS:          dit_ms          <= cfg_data;
        REG_ACTIVE_LOW:      active_low      <= cfg_data[0];
        REG_SIDETONE_ENABLE: sidetone_enable <= cfg_data[0];
        REG_PADDLE_ENABLE:   paddle_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pkeyer_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .dit           (dit_paddle),
    .dah           (dah_paddle),
    .sk            (straight_key),
    .paddle_enable (paddle_enable),
    .dit_ms        (dit_ms),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      key_line      <= res.key_down ^ active_low;
      sidetone_on   <= res.key_down & sidetone_enable;
      element_start <= res.start;
      busy_res      <= res.busy;
    end
  end

endmodule

`default_nettype wire

// ----- bench/paddle_keyer_with_element_memory_test.sv -----
// testbench for paddle_keyer_with_element_memory: directed and random tick words,
// with a keyer predictor, stepped per accepted tick word, checking every result word
// depends on pkeyer_pkg and the keyer rtl
`timescale 1ns / 100ps

module paddle_keyer_with_element_memory_test;
  import pkeyer_pkg::*;

  localparam int DAH_UNITS   = 3;
  localparam int CYCLE_LIMIT = 1_200_000;

  typedef struct {
    bit dit;
    bit dah;
    bit straight;
  } tick_word_t;

  typedef struct {
    bit     key_line;
    bit     tone;
    start_t start;
    bit     busy;
  } keying_word_t;

  typedef enum int {G_RELEASE, G_DIT, G_DAH, G_SQUEEZE, G_STRAIGHT, G_NOISE} gesture_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic dit_paddle = 1'b0;
  logic dah_paddle = 1'b0;
  logic straight_key = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic key_line;
  logic sidetone_on;
  logic [1:0] element_start;
  logic busy_res;

  // predictor copy of the registers and keyer state
  logic [DIT_W-1:0] cfg_dit = DIT_MS_RESET;
  bit cfg_act_low = 1'b0;
  bit cfg_tone_en = 1'b1;
  bit cfg_pad_en = 1'b1;
  phase_t ph = PH_IDLE;
  bit dah_running = 1'b0;
  logic [REM_W-1:0] ms_left = '0;
  bit mem_dit = 1'b0;
  bit mem_dah = 1'b0;
  bit key_down = 1'b0;

  tick_word_t pending_ticks[$];
  keying_word_t expected_keying[$];
  int words_queued = 0;
  int words_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  paddle_keyer_with_element_memory u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .dit_paddle(dit_paddle),
    .dah_paddle(dah_paddle),
    .straight_key(straight_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .key_line(key_line),
    .sidetone_on(sidetone_on),
    .element_start(element_start),
    .busy_res(busy_res)
  );

  always #1 clk = ~clk;

  function automatic logic [REM_W-1:0] dit_units();
    return (cfg_dit == '0) ? REM_W'(1) :
           (cfg_dit > DIT_MS_MAX) ? REM_W'(DIT_MS_MAX) : REM_W'(cfg_dit);
  endfunction

  function automatic start_t open_element(bit dah);
    dah_running = dah;
    key_down = 1'b1;
    ph = PH_MARK;
    ms_left = dah ? REM_W'(DAH_UNITS * dit_units()) : dit_units();
    return dah ? START_DAH : START_DIT;
  endfunction

  function automatic keying_word_t advance_keyer(tick_word_t t);
    keying_word_t w;
    start_t st;
    st = START_NONE;
    if (ph == PH_MARK || ph == PH_SPACE) begin
      if (t.dit) mem_dit = 1'b1;
      if (t.dah) mem_dah = 1'b1;
      if (ms_left != '0) ms_left = ms_left - 1'b1;
      if (ms_left == '0) begin
        if (ph == PH_MARK) begin
          key_down = 1'b0;
          ph = PH_SPACE;
          ms_left = dit_units();
        end else if (dah_running) begin
          mem_dah = 1'b0;
          ph = PH_IDLE;
        end else begin
          mem_dit = 1'b0;
          if (mem_dah) st = open_element(1'b1);
          else ph = PH_IDLE;
        end
      end
    end else begin
      ph = PH_IDLE;
      key_down = t.straight;
      if (cfg_pad_en) begin
        if (mem_dit || t.dit) st = open_element(1'b0);
        else if (mem_dah || t.dah) st = open_element(1'b1);
      end
    end
    w.key_line = key_down ^ cfg_act_low;
    w.tone = key_down & cfg_tone_en;
    w.start = st;
    w.busy = (ph != PH_IDLE);
    return w;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin : drive
    tick_word_t t;
    if (in_valid && in_ready) begin
      t.dit = dit_paddle;
      t.dah = dah_paddle;
      t.straight = straight_key;
      expected_keying.push_back(advance_keyer(t));
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        t = pending_ticks.pop_front();
        in_valid <= 1'b1;
        dit_paddle <= t.dit;
        dah_paddle <= t.dah;
        straight_key <= t.straight;
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        tx_gap = pick_gap(tx_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin : watch
    keying_word_t e;
    bit taken;
    taken = !rst && out_valid && out_ready;
    if (taken) begin
      words_checked++;
      if (expected_keying.size() == 0) begin
        $error("result word with no tick word pending");
        fail_count++;
      end else begin
        e = expected_keying.pop_front();
        check_field("key_line", e.key_line, key_line);
        check_field("sidetone_on", e.tone, sidetone_on);
        check_field("element_start", e.start, element_start);
        check_field("busy_res", e.busy, busy_res);
      end
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      rx_hold = pick_gap(rx_steady);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_tick(bit d, bit h, bit s);
    tick_word_t t;
    t.dit = d;
    t.dah = h;
    t.straight = s;
    pending_ticks.push_back(t);
    words_queued++;
  endtask

  task automatic add_quiet(int n);
    for (int i = 0; i < n; i++) add_tick(1'b0, 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (words_checked < words_queued);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DIT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DIT_MS:          cfg_dit = val;
      REG_ACTIVE_LOW:      cfg_act_low = val[0];
      REG_SIDETONE_ENABLE: cfg_tone_en = val[0];
      REG_PADDLE_ENABLE:   cfg_pad_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [DIT_W-1:0] dit, bit al, bit te, bit pe);
    write_reg(REG_DIT_MS, dit);
    write_reg(REG_ACTIVE_LOW, DIT_W'(al));
    write_reg(REG_SIDETONE_ENABLE, DIT_W'(te));
    write_reg(REG_PADDLE_ENABLE, DIT_W'(pe));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_gestures(int n);
    gesture_t g;
    int run;
    int r;
    run = 0;
    g = G_RELEASE;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        r = $urandom_range(0, 9);
        g = (r < 2) ? G_RELEASE : (r < 4) ? G_DIT : (r < 6) ? G_DAH :
            (r < 8) ? G_SQUEEZE : (r < 9) ? G_STRAIGHT : G_NOISE;
        run = $urandom_range(1, 12);
      end
      run--;
      case (g)
        G_RELEASE:  add_tick(1'b0, 1'b0, 1'b0);
        G_DIT:      add_tick(1'b1, 1'b0, 1'b0);
        G_DAH:      add_tick(1'b0, 1'b1, 1'b0);
        G_SQUEEZE:  add_tick(1'b1, 1'b1, 1'b0);
        G_STRAIGHT: add_tick(1'b0, 1'b0, 1'b1);
        default:    add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [DIT_W-1:0] dit;
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: straight key, then a squeeze starting a dit, with the dit paddle tapped mid-element
    add_tick(1'b0, 1'b0, 1'b1);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, 1'b1);
    add_quiet(10);
    add_tick(1'b1, 1'b0, 1'b0);
    add_quiet(120);
    wait_drained();

    // shortest dit, inverted key line, no sidetone
    set_config('0, 1'b1, 1'b0, 1'b1);
    add_tick(1'b0, 1'b0, 1'b1);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b1);
    add_quiet(4);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_quiet(6);
    wait_drained();

    // paddles switched off mid-element: element finishes, memory kept
    set_config(DIT_W'(3), 1'b0, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    wait_drained();
    set_config(DIT_W'(3), 1'b0, 1'b1, 1'b0);
    add_quiet(14);
    add_tick(1'b1, 1'b1, 1'b1);
    add_tick(1'b0, 1'b1, 1'b0);
    add_quiet(3);
    wait_drained();
    set_config(DIT_W'(3), 1'b0, 1'b1, 1'b1);
    add_quiet(10);
    wait_drained();

    // random gestures over a range of settings
    for (int p = 0; p < 8; p++) begin
      r = $urandom_range(0, 9);
      dit = (r == 0) ? '0 : (r == 1) ? DIT_W'(1) : DIT_W'($urandom_range(2, 6));
      set_config(dit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 4) != 0));
      add_gestures(50);
      wait_drained();
    end

    // longest dit length, clamped
    set_config('1, 1'b1, 1'b1, 1'b1);
    add_tick(1'b1, 1'b0, 1'b0);
    add_quiet(30);
    wait_drained();

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
